[hw/rtl/box_blur_3x3_rgb_macros.svh]
// assertion macros shared by the blur pipeline
`ifndef BOX_BLUR_3X3_RGB_MACROS_SVH
`define BOX_BLUR_3X3_RGB_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define BB3_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bb3_pkg.sv]
// shared types, constants and helpers of the 3x3 box blur
package bb3_pkg;

  localparam int NUM_CH    = 3;
  localparam int CHAN_W    = 8;
  localparam int POS_W     = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_WIDTH = 4096;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = CHAN_W + 2;
  localparam int PART_W    = CHAN_W + 3;
  localparam int SUM_W     = CHAN_W + 4;

  // floor(s/9) == (s*7282)>>16 for every nine-sample sum of 8-bit values
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP = 13'd7282;

  localparam logic [CFG_W-1:0] MIN_DIM       = 13'd3;
  localparam logic [CFG_W-1:0] MAX_DIM_W     = 13'd4096;
  localparam logic [CFG_W-1:0] MAX_DIM_H     = 13'd4096;
  localparam logic [CFG_W-1:0] WIDTH_RESET   = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET  = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // channel order inside a pixel word
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  typedef logic [NUM_CH-1:0][CHAN_W-1:0] pixel_t;
  typedef logic [NUM_CH-1:0][COL_W-1:0]  col_sum_t;
  typedef logic [NUM_CH-1:0][PART_W-1:0] part_sum_t;
  typedef logic [NUM_CH-1:0][SUM_W-1:0]  win_sum_t;

  // position info that travels with a result
  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             last;
  } pos_t;

  // clamp a dimension into 3..vmax and return the index of its last position
  function automatic logic [POS_W-1:0] last_index(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] vmax);
    logic [CFG_W-1:0] t;
    if (v < MIN_DIM) begin
      t = MIN_DIM - 13'd1;
    end else if (v > vmax) begin
      t = vmax - 13'd1;
    end else begin
      t = v - 13'd1;
    end
    return t[POS_W-1:0];
  endfunction

endpackage

[hw/rtl/bb3_in_if.sv]
// source pixel channel
interface bb3_in_if;
  logic                      valid;
  logic                      ready;
  logic [bb3_pkg::CHAN_W-1:0] in_red;
  logic [bb3_pkg::CHAN_W-1:0] in_green;
  logic [bb3_pkg::CHAN_W-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                output ready);
endinterface

[hw/rtl/bb3_out_if.sv]
// blurred pixel channel
interface bb3_out_if;
  logic                      valid;
  logic                      ready;
  logic [bb3_pkg::CHAN_W-1:0] out_red;
  logic [bb3_pkg::CHAN_W-1:0] out_green;
  logic [bb3_pkg::CHAN_W-1:0] out_blue;
  logic [bb3_pkg::POS_W-1:0]  out_x;
  logic [bb3_pkg::POS_W-1:0]  out_y;
  logic                      frame_last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_x, output out_y, output frame_last, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input out_x, input out_y, input frame_last, output ready);
endinterface

[hw/rtl/bb3_line_buf.sv]
// two line memories holding the rows above the current one
module bb3_line_buf (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [bb3_pkg::ADDR_W-1:0] rd_addr,
  input  logic                       wr_en,
  input  logic [bb3_pkg::ADDR_W-1:0] wr_addr,
  input  bb3_pkg::pixel_t            wr_upper,
  input  bb3_pkg::pixel_t            wr_middle,
  output bb3_pkg::pixel_t            rd_upper,
  output bb3_pkg::pixel_t            rd_middle
);

  bb3_pkg::pixel_t upper_mem_r  [bb3_pkg::MAX_WIDTH];
  bb3_pkg::pixel_t middle_mem_r [bb3_pkg::MAX_WIDTH];
  bb3_pkg::pixel_t rd_upper_r;
  bb3_pkg::pixel_t rd_middle_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem_r[wr_addr]  <= wr_upper;
      middle_mem_r[wr_addr] <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper_r  <= upper_mem_r[rd_addr];
      rd_middle_r <= middle_mem_r[rd_addr];
    end
  end

  assign rd_upper  = rd_upper_r;
  assign rd_middle = rd_middle_r;

endmodule

[hw/rtl/bb3_window.sv]
// 3x3 window kept as per-column sums of three rows
module bb3_window (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift,
  input  bb3_pkg::pixel_t     top_px,
  input  bb3_pkg::pixel_t     mid_px,
  input  bb3_pkg::pixel_t     new_px,
  output bb3_pkg::col_sum_t   col_sum,
  output bb3_pkg::part_sum_t  prev_sum
);

  bb3_pkg::col_sum_t col1_r;
  bb3_pkg::col_sum_t col2_r;

  always_comb begin
    for (int k = 0; k < bb3_pkg::NUM_CH; k++) begin
      col_sum[k] = {2'b00, top_px[k]} + {2'b00, mid_px[k]} + {2'b00, new_px[k]};
      prev_sum[k] = {1'b0, col1_r[k]} + {1'b0, col2_r[k]};
    end
  end

  // oldest column drops out, newest comes in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col1_r <= '0;
      col2_r <= '0;
    end else if (shift) begin
      col1_r <= col2_r;
      col2_r <= col_sum;
    end
  end

endmodule

[hw/rtl/bb3_div9.sv]
// divide by nine via reciprocal multiply, registered
module bb3_div9 (
  input  logic               clk,
  input  logic               en,
  input  bb3_pkg::win_sum_t  sum,
  output bb3_pkg::pixel_t    quot
);

  localparam int PROD_W = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;

  logic [bb3_pkg::NUM_CH-1:0][PROD_W-1:0] prod;
  bb3_pkg::pixel_t                         quot_r;

  always_comb begin
    for (int k = 0; k < bb3_pkg::NUM_CH; k++) begin
      prod[k] = {{bb3_pkg::RECIP_W{1'b0}}, sum[k]} *
                {{bb3_pkg::SUM_W{1'b0}}, bb3_pkg::RECIP};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < bb3_pkg::NUM_CH; k++) begin
        quot_r[k] <= prod[k][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
      end
    end
  end

  assign quot = quot_r;

endmodule

[hw/rtl/box_blur_3x3_rgb.sv]
// top level of the streaming 3x3 box blur for rgb frames
//
//   channel   dir   handshake       payload
//   in_bus    in    valid/ready     in_red, in_green, in_blue
//   out_bus   out   valid/ready     out_red, out_green, out_blue, out_x, out_y, frame_last
//   cfg_*     in    cfg_we only     cfg_idx selects width or height, cfg_data
//
// one pixel accepted per cycle while no stall from the output backs up to the first stage
// stages: line memory read, window update, sum, divide by nine into the output register
// each stage holds its item when the next one is full, so bubbles close up under stalls
// synchronous active-low reset clears counters, window sums, valids and sets 640x480
// line memories are not cleared; they are filled by the first two rows of a frame
`include "box_blur_3x3_rgb_macros.svh"

module box_blur_3x3_rgb (
  input  logic                          clk,
  input  logic                          rst_n,
  bb3_in_if.sink                        in_bus,
  bb3_out_if.source                     out_bus,
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data
);

  logic [bb3_pkg::POS_W-1:0] wlast_r;
  logic [bb3_pkg::POS_W-1:0] hlast_r;
  logic [bb3_pkg::POS_W-1:0] x_r;
  logic [bb3_pkg::POS_W-1:0] y_r;
  logic [bb3_pkg::POS_W-1:0] x_nxt;
  logic [bb3_pkg::POS_W-1:0] y_nxt;

  logic            in_acc;
  logic            last_col;
  logic            last_row;
  bb3_pkg::pixel_t in_px;
  bb3_pkg::pos_t   in_pos;

  // stage 1: memory read in flight
  logic                       s1_v_r;
  logic                       s1_emit_r;
  bb3_pkg::pixel_t            s1_px_r;
  logic [bb3_pkg::ADDR_W-1:0] s1_addr_r;
  bb3_pkg::pos_t              s1_pos_r;
  // stage 2: partial window sums
  logic                       s2_v_r;
  bb3_pkg::part_sum_t         s2_part_r;
  bb3_pkg::col_sum_t          s2_col_r;
  bb3_pkg::pos_t              s2_pos_r;
  // stage 3: full window sums
  logic                       s3_v_r;
  bb3_pkg::win_sum_t          s3_sum_r;
  bb3_pkg::pos_t              s3_pos_r;
  // output register
  logic                       out_v_r;
  bb3_pkg::pos_t              out_pos_r;
  bb3_pkg::pixel_t            out_px;

  logic out_free, s3_free, s2_free, s1_free;
  logic s3_go, s2_go, s1_go;

  bb3_pkg::pixel_t    rd_upper;
  bb3_pkg::pixel_t    rd_middle;
  bb3_pkg::col_sum_t  col_sum;
  bb3_pkg::part_sum_t prev_sum;
  bb3_pkg::win_sum_t  win_sum;

  // stage flow control
  assign out_free = !out_v_r || out_bus.ready;
  assign s3_go    = s3_v_r && out_free;
  assign s3_free  = !s3_v_r || out_free;
  assign s2_go    = s2_v_r && s3_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_go    = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;

  assign in_bus.ready = s1_free;
  assign in_acc       = in_bus.valid && s1_free;

  assign in_px[bb3_pkg::CH_RED]   = in_bus.in_red;
  assign in_px[bb3_pkg::CH_GREEN] = in_bus.in_green;
  assign in_px[bb3_pkg::CH_BLUE]  = in_bus.in_blue;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= bb3_pkg::last_index(bb3_pkg::WIDTH_RESET, bb3_pkg::MAX_DIM_W);
      hlast_r <= bb3_pkg::last_index(bb3_pkg::HEIGHT_RESET, bb3_pkg::MAX_DIM_H);
    end else if (cfg_we) begin
      case (cfg_idx)
        bb3_pkg::REG_FRAME_WIDTH: begin
          wlast_r <= bb3_pkg::last_index(cfg_data, bb3_pkg::MAX_DIM_W);
        end
        bb3_pkg::REG_FRAME_HEIGHT: begin
          hlast_r <= bb3_pkg::last_index(cfg_data, bb3_pkg::MAX_DIM_H);
        end
        default: begin
        end
      endcase
    end
  end

  // raster position counters
  always_comb begin
    last_col = (x_r >= wlast_r);
    last_row = (y_r >= hlast_r);
    if (last_col) begin
      x_nxt = '0;
      y_nxt = last_row ? '0 : y_r + 12'd1;
    end else begin
      x_nxt = x_r + 12'd1;
      y_nxt = y_r;
    end
    in_pos.x    = x_r - 12'd1;
    in_pos.y    = y_r - 12'd1;
    in_pos.last = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else if (in_acc) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      // only interior pixels go on past the window
      if (s1_go && s1_emit_r) begin
        s2_v_r <= 1'b1;
      end else if (s2_go) begin
        s2_v_r <= 1'b0;
      end
      if (s2_go) begin
        s3_v_r <= 1'b1;
      end else if (s3_go) begin
        s3_v_r <= 1'b0;
      end
      if (s3_go) begin
        out_v_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= in_px;
      s1_addr_r <= x_r[bb3_pkg::ADDR_W-1:0];
      s1_pos_r  <= in_pos;
      s1_emit_r <= (x_r >= 12'd2) && (y_r >= 12'd2);
    end
    if (s1_go) begin
      s2_part_r <= prev_sum;
      s2_col_r  <= col_sum;
      s2_pos_r  <= s1_pos_r;
    end
    if (s2_go) begin
      s3_sum_r <= win_sum;
      s3_pos_r <= s2_pos_r;
    end
    if (s3_go) begin
      out_pos_r <= s3_pos_r;
    end
  end

  always_comb begin
    for (int k = 0; k < bb3_pkg::NUM_CH; k++) begin
      win_sum[k] = {1'b0, s2_part_r[k]} + {2'b00, s2_col_r[k]};
    end
  end

  // upper row takes the old middle row, middle row takes the new pixel
  bb3_line_buf u_line_buf (
    .clk       (clk),
    .rd_en     (in_acc),
    .rd_addr   (x_r[bb3_pkg::ADDR_W-1:0]),
    .wr_en     (s1_go),
    .wr_addr   (s1_addr_r),
    .wr_upper  (rd_middle),
    .wr_middle (s1_px_r),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle)
  );

  bb3_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift    (s1_go),
    .top_px   (rd_upper),
    .mid_px   (rd_middle),
    .new_px   (s1_px_r),
    .col_sum  (col_sum),
    .prev_sum (prev_sum)
  );

  bb3_div9 u_div9 (
    .clk  (clk),
    .en   (s3_go),
    .sum  (s3_sum_r),
    .quot (out_px)
  );

  assign out_bus.valid      = out_v_r;
  assign out_bus.out_red    = out_px[bb3_pkg::CH_RED];
  assign out_bus.out_green  = out_px[bb3_pkg::CH_GREEN];
  assign out_bus.out_blue   = out_px[bb3_pkg::CH_BLUE];
  assign out_bus.out_x      = out_pos_r.x;
  assign out_bus.out_y      = out_pos_r.y;
  assign out_bus.frame_last = out_pos_r.last;

  // a new read never hits the line entry still waiting for its write
  `BB3_ASSERT_SAME(a_no_rw_clash, in_acc && s1_go, x_r[bb3_pkg::ADDR_W-1:0] != s1_addr_r, "line memory read meets pending write")
  // only interior pixels come out
  `BB3_ASSERT_SAME(a_interior_only, out_v_r, out_pos_r.x != 12'd0 && out_pos_r.y != 12'd0, "border pixel emitted")
  // a blocked sum stage keeps its transaction
  `BB3_ASSERT_NEXT(a_s3_hold, s3_v_r && !out_free, s3_v_r && $stable(s3_sum_r), "sum stage lost data under stall")

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for the streaming 3x3 rgb box blur
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned RANDOM_TARGET = 1100;
  localparam int unsigned CALM_TAIL     = 300;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 2_500_000;
  localparam int unsigned BLUR_TAPS     = 9;

  // indexes with no register behind them
  localparam logic [bb3_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [bb3_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_BRIGHT} pix_mode_t;

  typedef logic [bb3_pkg::CHAN_W-1:0] chan_t;
  typedef logic [bb3_pkg::POS_W-1:0]  pos_val_t;
  typedef logic [bb3_pkg::CFG_W-1:0]  cfg_val_t;
  typedef logic [bb3_pkg::SUM_W-1:0]  sum_val_t;

  typedef struct {
    chan_t    red;
    chan_t    green;
    chan_t    blue;
    pos_val_t x;
    pos_val_t y;
    logic     last;
  } blurred_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we;
  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_idx;
  cfg_val_t                      cfg_data;

  bb3_in_if  pix_in ();
  bb3_out_if pix_out ();

  box_blur_3x3_rgb i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (pix_in),
    .out_bus  (pix_out),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // blur model state; line stores start unknown so a read of an unwritten entry shows up
  cfg_val_t        width_reg;
  cfg_val_t        height_reg;
  bb3_pkg::pixel_t upper_line [bb3_pkg::MAX_WIDTH];
  bb3_pkg::pixel_t middle_line [bb3_pkg::MAX_WIDTH];
  bb3_pkg::pixel_t window [3][3];
  pos_val_t        col_pos;
  pos_val_t        row_pos;

  bb3_pkg::pixel_t pixel_queue[$];
  blurred_t        blurred_pending[$];

  int unsigned send_odds;
  int unsigned stall_odds;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned pixels_taken = 0;
  int unsigned geometries = 0;
  int unsigned random_items = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  function automatic int unsigned eff_dim(cfg_val_t v, cfg_val_t vmax);
    if (v < bb3_pkg::MIN_DIM) return 32'(bb3_pkg::MIN_DIM);
    if (v > vmax) return 32'(vmax);
    return 32'(v);
  endfunction

  // pixels still needed to bring the counters back to the frame origin
  function automatic int unsigned pixels_to_frame_end();
    int unsigned w = eff_dim(width_reg, bb3_pkg::MAX_DIM_W);
    int unsigned h = eff_dim(height_reg, bb3_pkg::MAX_DIM_H);
    int unsigned x = 32'(col_pos);
    int unsigned y = 32'(row_pos);
    int unsigned n = 1;
    while (!(x >= w - 1 && y >= h - 1)) begin
      if (x >= w - 1) begin
        x = 0;
        y++;
      end else begin
        x++;
      end
      n++;
    end
    return n;
  endfunction

  function automatic bb3_pkg::pixel_t rand_pixel(pix_mode_t mode);
    bb3_pkg::pixel_t p;
    for (int ch = 0; ch < bb3_pkg::NUM_CH; ch++) begin
      case (mode)
        PIX_EXTREME: p[ch] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        PIX_BRIGHT:  p[ch] = 8'd252 + chan_t'($urandom_range(0, 3));
        default:     p[ch] = chan_t'($urandom_range(0, 255));
      endcase
    end
    return p;
  endfunction

  // advance the window by one source pixel and queue the blurred pixel it completes
  task automatic blur_pixel(bb3_pkg::pixel_t px);
    int unsigned                  w;
    int unsigned                  h;
    int unsigned                  x;
    int unsigned                  y;
    logic [bb3_pkg::ADDR_W-1:0]   xi;
    logic                         last_col;
    logic                         last_row;
    sum_val_t                     total;
    bb3_pkg::pixel_t              mean;
    blurred_t                     res;
    w = eff_dim(width_reg, bb3_pkg::MAX_DIM_W);
    h = eff_dim(height_reg, bb3_pkg::MAX_DIM_H);
    x = 32'(col_pos);
    y = 32'(row_pos);
    xi = col_pos[bb3_pkg::ADDR_W-1:0];
    last_col = (x >= w - 1);
    last_row = (y >= h - 1);
    for (int r = 0; r < 3; r++) begin
      window[r][0] = window[r][1];
      window[r][1] = window[r][2];
    end
    window[0][2] = upper_line[xi];
    window[1][2] = middle_line[xi];
    window[2][2] = px;
    upper_line[xi] = middle_line[xi];
    middle_line[xi] = px;
    if (x >= 2 && y >= 2) begin
      for (int ch = 0; ch < bb3_pkg::NUM_CH; ch++) begin
        total = '0;
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            total += sum_val_t'(window[r][c][ch]);
          end
        end
        mean[ch] = chan_t'(total / BLUR_TAPS);
      end
      res.red   = mean[bb3_pkg::CH_RED];
      res.green = mean[bb3_pkg::CH_GREEN];
      res.blue  = mean[bb3_pkg::CH_BLUE];
      res.x     = pos_val_t'(x - 1);
      res.y     = pos_val_t'(y - 1);
      res.last  = last_col && last_row;
      blurred_pending.push_back(res);
    end
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? '0 : pos_val_t'(y + 1);
    end else begin
      col_pos = pos_val_t'(x + 1);
    end
  endtask

  task automatic check_field(string name, pos_val_t want, pos_val_t got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic write_reg(logic [bb3_pkg::CFG_IDX_W-1:0] idx, cfg_val_t value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      bb3_pkg::REG_FRAME_WIDTH:  width_reg = value;
      bb3_pkg::REG_FRAME_HEIGHT: height_reg = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || pix_in.valid !== 1'b0 || blurred_pending.size() != 0);
    // border pixels give no result but may still be in the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixels(int unsigned count, pix_mode_t mode);
    @(negedge clk);
    repeat (count) pixel_queue.push_back(rand_pixel(mode));
    wait_idle();
  endtask

  // source side: offers queued pixels, idles in bursts, never drops an offered transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_in.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        blur_pixel(pixel_queue.pop_front());
        pixels_taken++;
      end
      if (!pix_in.valid || pix_in.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          pix_in.valid <= 1'b0;
        end else if (pixel_queue.size() != 0 && send_odds != 0 &&
                     $urandom_range(1, send_odds) == 1) begin
          gap_left = $urandom_range(0, 11);
          pix_in.valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          pix_in.valid    <= 1'b1;
          pix_in.in_red   <= pixel_queue[0][bb3_pkg::CH_RED];
          pix_in.in_green <= pixel_queue[0][bb3_pkg::CH_GREEN];
          pix_in.in_blue  <= pixel_queue[0][bb3_pkg::CH_BLUE];
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // result side: compares each transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    blurred_t want;
    if (!rst_n) begin
      pix_out.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (blurred_pending.size() == 0) begin
          $error("unexpected blurred pixel at x=%0d y=%0d", pix_out.out_x, pix_out.out_y);
          mismatches++;
        end else begin
          want = blurred_pending.pop_front();
          check_field("out_red", pos_val_t'(want.red), pos_val_t'(pix_out.out_red));
          check_field("out_green", pos_val_t'(want.green), pos_val_t'(pix_out.out_green));
          check_field("out_blue", pos_val_t'(want.blue), pos_val_t'(pix_out.out_blue));
          check_field("out_x", want.x, pix_out.out_x);
          check_field("out_y", want.y, pix_out.out_y);
          check_field("frame_last", pos_val_t'(want.last), pos_val_t'(pix_out.frame_last));
          results_checked++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        pix_out.ready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        stall_left = $urandom_range(0, 11);
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("no progress after %0d cycles, %0d blurred pixels still pending",
               cycle_count, blurred_pending.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned     w;
    int unsigned     h;
    int unsigned     n;
    bb3_pkg::pixel_t px;
    pix_mode_t       mode;
    int unsigned     odds_menu [4];
    odds_menu = '{0, 3, 8, 20};
    cfg_we          = 1'b0;
    cfg_idx         = bb3_pkg::REG_FRAME_WIDTH;
    cfg_data        = '0;
    pix_in.valid    = 1'b0;
    pix_in.in_red   = '0;
    pix_in.in_green = '0;
    pix_in.in_blue  = '0;
    pix_out.ready   = 1'b0;
    width_reg  = bb3_pkg::WIDTH_RESET;
    height_reg = bb3_pkg::HEIGHT_RESET;
    col_pos    = '0;
    row_pos    = '0;
    foreach (window[r, c]) window[r][c] = '0;
    send_odds  = 8;
    stall_odds = 8;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: one full row and the start of the second
    send_pixels(640 + 5, PIX_UNIFORM);
    // shrinking both dimensions mid-frame wraps the row now and ends the frame a row later
    write_reg(bb3_pkg::REG_FRAME_WIDTH, 13'd5);
    write_reg(bb3_pkg::REG_FRAME_HEIGHT, 13'd3);
    send_pixels(pixels_to_frame_end(), PIX_UNIFORM);
    geometries++;

    // writes to unused indexes must leave the geometry alone
    write_reg(REG_UNUSED_2, cfg_val_t'($urandom));
    write_reg(REG_UNUSED_3, cfg_val_t'($urandom));

    // undersized values clamp to 3x3: saturated, dark and striped frames
    write_reg(bb3_pkg::REG_FRAME_WIDTH, 13'd0);
    write_reg(bb3_pkg::REG_FRAME_HEIGHT, 13'd2);
    @(negedge clk);
    for (int i = 0; i < 9; i++) pixel_queue.push_back('1);
    for (int i = 0; i < 9; i++) pixel_queue.push_back('0);
    for (int i = 0; i < 9; i++) begin
      px[bb3_pkg::CH_RED]   = (i % 2) ? 8'hAA : 8'h55;
      px[bb3_pkg::CH_GREEN] = (i % 2) ? 8'h55 : 8'hAA;
      px[bb3_pkg::CH_BLUE]  = chan_t'(i * 31);
      pixel_queue.push_back(px);
    end
    wait_idle();
    geometries++;

    // oversized values clamp to the largest frame: the start of a long first row, then shrink to 3x3
    write_reg(bb3_pkg::REG_FRAME_WIDTH, 13'h1FFF);
    write_reg(bb3_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
    send_pixels(30, PIX_UNIFORM);
    write_reg(bb3_pkg::REG_FRAME_WIDTH, 13'd3);
    write_reg(bb3_pkg::REG_FRAME_HEIGHT, 13'd3);
    send_pixels(pixels_to_frame_end(), PIX_UNIFORM);
    // tall frame: twenty rows, then the height shrinks
    write_reg(bb3_pkg::REG_FRAME_WIDTH, 13'd3);
    write_reg(bb3_pkg::REG_FRAME_HEIGHT, 13'd5000);
    send_pixels(60, PIX_BRIGHT);
    write_reg(bb3_pkg::REG_FRAME_HEIGHT, 13'd3);
    send_pixels(pixels_to_frame_end(), PIX_BRIGHT);
    geometries += 2;

    while (random_items < RANDOM_TARGET) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 48) : $urandom_range(3, 16);
      h = $urandom_range(3, 8);
      if (random_items + CALM_TAIL >= RANDOM_TARGET) begin
        send_odds  = 0;
        stall_odds = 0;
      end else begin
        send_odds  = odds_menu[$urandom_range(0, 3)];
        stall_odds = odds_menu[$urandom_range(0, 3)];
      end
      write_reg(bb3_pkg::REG_FRAME_WIDTH,
                ($urandom_range(0, 9) == 0) ? cfg_val_t'($urandom_range(0, 2)) : cfg_val_t'(w));
      write_reg(bb3_pkg::REG_FRAME_HEIGHT,
                ($urandom_range(0, 9) == 0) ? cfg_val_t'($urandom_range(0, 2)) : cfg_val_t'(h));
      mode = pix_mode_t'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) begin
        // stop partway, shrink the geometry, then finish the frame under it
        n = $urandom_range(1, pixels_to_frame_end() - 1);
        send_pixels(n, mode);
        random_items += n;
        write_reg(bb3_pkg::REG_FRAME_WIDTH,
                  cfg_val_t'($urandom_range(3, eff_dim(width_reg, bb3_pkg::MAX_DIM_W))));
        if ($urandom_range(0, 1) == 1) begin
          write_reg(bb3_pkg::REG_FRAME_HEIGHT,
                    cfg_val_t'($urandom_range(3, eff_dim(height_reg, bb3_pkg::MAX_DIM_H))));
        end
        n = pixels_to_frame_end();
        send_pixels(n, mode);
        random_items += n;
      end else begin
        repeat ($urandom_range(1, 2)) begin
          n = pixels_to_frame_end();
          send_pixels(n, mode);
          random_items += n;
        end
      end
      geometries++;
    end

    wait_idle();
    $display("blur run: %0d source pixels accepted, %0d blurred pixels compared, %0d geometries",
             pixels_taken, results_checked, geometries);
    $display("%s", {"geometries ran from clamped 3x3 to oversized 4096x4096 rows, ",
                    "with mid-frame shrinks"});
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/bb3_pkg.sv
hw/rtl/bb3_in_if.sv
hw/rtl/bb3_out_if.sv
hw/rtl/bb3_line_buf.sv
hw/rtl/bb3_window.sv
hw/rtl/bb3_div9.sv
hw/rtl/box_blur_3x3_rgb.sv
tb/sv/testbench.sv
